>>> rtl/core/ess_pkg.sv
package ess_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_SEARCH = 2'd3
  } ess_op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SLOT_FULL  = 3'd1,
    ST_BAD_INDEX  = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_BAD_LEN    = 3'd4
  } ess_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DISPATCH,
    S_EVAL,
    S_PROBE
  } ess_state_t;

  // S_EVAL and S_PROBE both read the RAM word requested in the cycle before;
  // S_PROBE alternates between issuing a read of mid and evaluating it, so
  // no separate issue state is needed for the search loop.

  typedef struct packed {
    logic [1:0]  cmd;
    logic        channel;
    logic [10:0] slice_count;
    logic [7:0]  element_index;
    logic [9:0]  slice_start;
  } ess_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [10:0] start_address;
    logic [7:0]  found_index;
    logic [8:0]  element_count;
  } ess_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture the command beat
    logic rd;         // issue a table read
    logic srch_init;  // lo = 0, hi = count
    logic srch_upd;   // narrow the search window
    logic emit;       // form and register the result
    logic hit;        // search result is a match
  } ess_ctl_t;

  // datapath -> controller
  typedef struct packed {
    ess_op_t op;
    logic    reject;      // append or lookup fails before any read
    logic    srch_empty;  // search window is empty
    logic    srch_hit;    // word just read equals the key
  } ess_sts_t;

endpackage

>>> rtl/core/ess_ram.sv
module ess_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q_r <= mem[raddr];
  end

  assign rdata = q_r;

endmodule

>>> rtl/core/ess_ctrl.sv
module ess_ctrl
  import ess_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  ess_sts_t sts,
  output ess_ctl_t ctl,
  output logic     busy
);

  ess_state_t state_r, state_nxt;
  logic       probe_pend_r, probe_pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      probe_pend_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      probe_pend_r <= probe_pend_nxt;
    end
  end

  // S_PROBE runs in two phases: with no read pending, test the window and
  // issue a read of mid; with a read pending, compare and narrow.
  always_comb begin
    state_nxt      = state_r;
    probe_pend_nxt = probe_pend_r;
    ctl            = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.op)
          OP_CLEAR: begin
            ctl.emit  = 1'b1;
            state_nxt = S_IDLE;
          end
          OP_APPEND, OP_LOOKUP: begin
            if (sts.reject) begin
              ctl.emit  = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              ctl.rd    = 1'b1;
              state_nxt = S_EVAL;
            end
          end
          default: begin
            ctl.srch_init  = 1'b1;
            probe_pend_nxt = 1'b0;
            state_nxt      = S_PROBE;
          end
        endcase
      end
      S_EVAL: begin
        ctl.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_PROBE: begin
        if (!probe_pend_r) begin
          if (sts.srch_empty) begin
            ctl.emit  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            ctl.rd         = 1'b1;
            probe_pend_nxt = 1'b1;
          end
        end else begin
          probe_pend_nxt = 1'b0;
          if (sts.srch_hit) begin
            ctl.emit  = 1'b1;
            ctl.hit   = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            ctl.srch_upd = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

>>> rtl/core/ess_datapath.sv
module ess_datapath
  import ess_pkg::*;
#(
  parameter int SLOT_CAPACITY = 1024,
  parameter int MAX_ELEMENTS  = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  input  ess_in_t  in_item,
  input  ess_ctl_t ctl,
  output ess_sts_t sts,
  output logic     out_valid,
  output ess_out_t out_item
);

  localparam int CW    = $clog2(MAX_ELEMENTS + 1);
  localparam int AW    = $clog2(SLOT_CAPACITY + 1);
  localparam int ROW   = MAX_ELEMENTS + 1;
  localparam int DEPTH = 2 * ROW;
  localparam int MAW   = $clog2(DEPTH);
  localparam int EW    = (CW > 8) ? CW : 8;
  localparam int KW    = (AW > 10) ? AW : 10;
  localparam int SW    = ((AW > 11) ? AW : 11) + 1;

  ess_op_t     op_r;
  logic        ch_r;
  logic [10:0] len_r;
  logic [7:0]  eidx_r;
  logic [9:0]  key_r;
  logic [CW-1:0] cnt_r [2];
  logic [CW-1:0] lo_r, hi_r;
  logic        rd_zero_r;
  logic        out_valid_r;
  ess_out_t    out_item_r;

  logic [CW-1:0]  count, mid, rd_idx, cnt_new;
  logic           bad_len, bad_idx, reject, over, hit, less, we;
  logic [MAW-1:0] row_base, rd_addr, wr_addr;
  logic [AW-1:0]  ram_q, rd_val;
  logic [SW-1:0]  sum;
  ess_out_t       res_nxt;

  assign count   = cnt_r[ch_r];
  assign mid     = lo_r + ((hi_r - lo_r) >> 1);
  assign bad_len = (len_r == 11'd0) || (count >= CW'(MAX_ELEMENTS));
  assign bad_idx = EW'(eidx_r) >= EW'(count);

  always_comb begin
    case (op_r)
      OP_APPEND: reject = bad_len;
      OP_LOOKUP: reject = bad_idx;
      default:   reject = 1'b0;
    endcase
  end

  always_comb begin
    case (op_r)
      OP_APPEND: rd_idx = count;
      OP_LOOKUP: rd_idx = CW'(eidx_r);
      default:   rd_idx = mid;
    endcase
  end

  assign row_base = ch_r ? MAW'(ROW) : '0;
  assign rd_addr  = row_base + MAW'(rd_idx);
  assign wr_addr  = row_base + MAW'(count) + MAW'(1);

  // entry zero of each row is always 0
  assign rd_val = rd_zero_r ? '0 : ram_q;
  assign sum    = SW'(rd_val) + SW'(len_r);
  assign over   = sum > SW'(SLOT_CAPACITY);
  assign hit    = KW'(rd_val) == KW'(key_r);
  assign less   = KW'(rd_val) < KW'(key_r);
  assign we     = ctl.emit && (op_r == OP_APPEND) && !reject && !over;

  ess_ram #(
    .W(AW),
    .D(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(wr_addr),
    .wdata(sum[AW-1:0]),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  always_comb begin
    cnt_new = count;
    res_nxt = '0;
    res_nxt.status = ST_OK;
    case (op_r)
      OP_CLEAR: begin
        cnt_new = '0;
      end
      OP_APPEND: begin
        if (reject) begin
          res_nxt.status = ST_BAD_LEN;
        end else if (over) begin
          res_nxt.status = ST_SLOT_FULL;
        end else begin
          cnt_new               = count + CW'(1);
          res_nxt.start_address = 11'(rd_val);
        end
      end
      OP_LOOKUP: begin
        if (reject) begin
          res_nxt.status = ST_BAD_INDEX;
        end else begin
          res_nxt.start_address = 11'(rd_val);
        end
      end
      default: begin
        if (ctl.hit) begin
          res_nxt.found_index = 8'(mid);
        end else begin
          res_nxt.status = ST_NOT_FOUND;
        end
      end
    endcase
    res_nxt.element_count = 9'(cnt_new);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r[0]    <= '0;
      cnt_r[1]    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.emit;
      if (ctl.emit) begin
        cnt_r[ch_r] <= cnt_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_r   <= ess_op_t'(in_item.cmd);
      ch_r   <= in_item.channel;
      len_r  <= in_item.slice_count;
      eidx_r <= in_item.element_index;
      key_r  <= in_item.slice_start;
    end
    if (ctl.rd) begin
      rd_zero_r <= (rd_idx == '0);
    end
    if (ctl.srch_init) begin
      lo_r <= '0;
      hi_r <= count;
    end else if (ctl.srch_upd) begin
      if (less) begin
        lo_r <= mid + CW'(1);
      end else begin
        hi_r <= mid;
      end
    end
    if (ctl.emit) begin
      out_item_r <= res_nxt;
    end
  end

  assign sts.op         = op_r;
  assign sts.reject     = reject;
  assign sts.srch_empty = (lo_r >= hi_r);
  assign sts.srch_hit   = hit;
  assign out_valid      = out_valid_r;
  assign out_item       = out_item_r;

endmodule

>>> rtl/core/element_slice_start_table.sv
// Element start table for two channels. Each channel holds an element count
// and a strictly increasing table of start slots in a slot memory of
// SLOT_CAPACITY slots; entry i is the first slot of element i and entry
// "count" is the first free slot. Issue a command beat by raising start
// while busy is low: clear empties a channel, append reserves a run of
// slots and returns its start, lookup maps an element index to its start,
// and search binary-searches a start slot for its element index. Every
// command returns exactly one result beat, shown on out_item for a single
// cycle with out_valid high; the receiver cannot stall it, so capture it
// then. The result for clear and for rejected commands is formed in the
// dispatch state; append and lookup first make one registered read of
// the start table; search runs k probes (at most ceil(log2(count+1)))
// before its result, where each probe is one registered read of the
// start table followed by a compare.
// busy falls in the cycle out_valid rises, so the next beat can be taken
// while the result is on the port. No clearing pass is needed after
// reset: entry zero of each channel reads as 0 by construction.
module element_slice_start_table
  import ess_pkg::*;
#(
  parameter int SLOT_CAPACITY = 1024,
  parameter int MAX_ELEMENTS  = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ess_in_t  in_item,
  output logic     out_valid,
  output ess_out_t out_item
);

  ess_ctl_t ctl;
  ess_sts_t sts;

  // sequencing: accept, dispatch, read, probe loop
  ess_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .sts  (sts),
    .ctl  (ctl),
    .busy (busy)
  );

  // counts, start table, search window and result register
  ess_datapath #(
    .SLOT_CAPACITY(SLOT_CAPACITY),
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .ctl      (ctl),
    .sts      (sts),
    .out_valid(out_valid),
    .out_item (out_item)
  );

endmodule

>>> rtl/core/ess_checker.sv
module ess_checker
  import ess_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input ess_in_t  in_item,
  input logic     out_valid,
  input ess_out_t out_item
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two result beats in a row");

  a_fail_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status != ST_OK)) |->
      (out_item.start_address == 11'd0) && (out_item.found_index == 8'd0))
    else $error("failing result carries nonzero fields");

  a_input_unused: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status == ST_NOT_FOUND)) |-> !$past(busy, 1) == 1'b0)
    else $error("not-found result without a command in flight");

endmodule

bind element_slice_start_table ess_checker u_ess_checker (.*);

>>> tb/start_table_checker.sv
`timescale 1ns / 1ps

module start_table_checker
  import ess_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  ess_in_t  in_item,
  input  logic     out_valid,
  input  ess_out_t out_item,
  output int       mismatches,
  output int       owed
);

  localparam int SLOT_CAPACITY = 1024;
  localparam int MAX_ELEMENTS  = 256;

  logic [8:0]  elem_count [2];
  logic [10:0] start_slot [2][MAX_ELEMENTS + 1];
  ess_out_t    awaited_results [$];

  // Apply one command beat to the shadow tables and return the result beat it owes.
  function automatic ess_out_t table_response(input ess_in_t beat);
    ess_out_t res;
    int       ch;
    int       cnt;
    int       base;
    int       len;
    int       key;
    int       lo;
    int       hi;
    int       mid;
    logic     hit;
    res = '0;
    ch  = int'(beat.channel);
    cnt = int'(elem_count[ch]);
    len = int'(beat.slice_count);
    key = int'(beat.slice_start);
    case (ess_op_t'(beat.cmd))
      OP_CLEAR: begin
        cnt = 0;
        start_slot[ch][0] = '0;
      end
      OP_APPEND: begin
        if (len == 0 || cnt >= MAX_ELEMENTS) begin
          res.status = ST_BAD_LEN;
        end else begin
          base = int'(start_slot[ch][cnt]);
          if (base + len > SLOT_CAPACITY) begin
            res.status = ST_SLOT_FULL;
          end else begin
            start_slot[ch][cnt + 1] = 11'(base + len);
            cnt++;
            res.start_address = 11'(base);
          end
        end
      end
      OP_LOOKUP: begin
        if (int'(beat.element_index) >= cnt) res.status = ST_BAD_INDEX;
        else res.start_address = start_slot[ch][beat.element_index];
      end
      OP_SEARCH: begin
        lo  = 0;
        hi  = cnt;
        hit = 1'b0;
        while (lo < hi && !hit) begin
          mid = lo + (hi - lo) / 2;
          if (int'(start_slot[ch][mid]) == key) begin
            hit = 1'b1;
            res.found_index = 8'(mid);
          end else if (int'(start_slot[ch][mid]) < key) begin
            lo = mid + 1;
          end else begin
            hi = mid;
          end
        end
        if (!hit) res.status = ST_NOT_FOUND;
      end
      default: ;
    endcase
    elem_count[ch] = 9'(cnt);
    res.element_count = 9'(cnt);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    ess_out_t want;
    if (!rst_n) begin
      for (int c = 0; c < 2; c++) begin
        elem_count[c] = '0;
        for (int i = 0; i <= MAX_ELEMENTS; i++) start_slot[c][i] = '0;
      end
      awaited_results.delete();
      mismatches = 0;
    end else begin
      // Retire the result beat first: it belongs to a command taken earlier.
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with nothing awaited: st=%0d sa=%0d fi=%0d n=%0d",
                   $time, out_item.status, out_item.start_address,
                   out_item.found_index, out_item.element_count);
        end else begin
          want = awaited_results.pop_front();
          if (out_item.status !== want.status ||
              out_item.start_address !== want.start_address ||
              out_item.found_index !== want.found_index ||
              out_item.element_count !== want.element_count) begin
            mismatches++;
            $display("%0t: expected st=%0d sa=%0d fi=%0d n=%0d, got st=%0d sa=%0d fi=%0d n=%0d",
                     $time, want.status, want.start_address, want.found_index,
                     want.element_count, out_item.status, out_item.start_address,
                     out_item.found_index, out_item.element_count);
          end
        end
      end
      if (start && !busy) awaited_results.push_back(table_response(in_item));
    end
    owed = awaited_results.size();
  end

endmodule

>>> tb/element_slice_start_table_test.sv
`timescale 1ns / 1ps

module element_slice_start_table_test;
  import ess_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     start;
  logic     busy;
  ess_in_t  in_item;
  logic     out_valid;
  ess_out_t out_item;
  int       mismatches;
  int       owed;
  int       sent;

  element_slice_start_table uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  start_table_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .mismatches(mismatches),
    .owed      (owed)
  );

  always #10 clk = ~clk;

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("element_slice_start_table: mismatch");
    $finish;
  end

  // Sender idle chance per cycle, stepped through phases of 300 beats:
  // back to back, mostly idle, lightly idle, then alternating stretches.
  function automatic int idle_pct();
    case ((sent / 300) % 4)
      0: return 0;
      1: return 86;
      2: return 9;
      default: return ((sent / 25) % 2) ? 86 : 0;
    endcase
  endfunction

  // Build a command beat; the fields the command ignores carry noise.
  function automatic ess_in_t make_beat(input ess_op_t op, input logic ch, input int arg);
    ess_in_t b;
    b = ess_in_t'($urandom);
    b.cmd     = op;
    b.channel = ch;
    case (op)
      OP_APPEND: b.slice_count   = 11'(arg);
      OP_LOOKUP: b.element_index = 8'(arg);
      OP_SEARCH: b.slice_start   = 10'(arg);
      default: ;
    endcase
    return b;
  endfunction

  // Drive one beat at the falling edge and hold it until a rising edge sees busy low.
  task automatic send_beat(input ess_in_t beat);
    while ($urandom_range(99, 0) < idle_pct()) begin
      start   = 1'b0;
      in_item = ess_in_t'($urandom);
      @(negedge clk);
    end
    start   = 1'b1;
    in_item = beat;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start = 1'b0;
    sent++;
  endtask

  initial begin : stimulus
    int   rnd_sent;
    int   run_left;
    int   app_n;
    int   slot_end;
    int   r;
    int   len;
    int   clear_pct;
    int   app_pct;
    logic fill;
    logic first;
    logic ep_ch;
    logic ch;

    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    sent    = 0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: empty-table misses, zero length, exact fill of the slot memory,
    // overflow with the widest length, lookups and searches at both ends, clears.
    send_beat(make_beat(OP_LOOKUP, 1'b0, 0));
    send_beat(make_beat(OP_SEARCH, 1'b0, 0));
    send_beat(make_beat(OP_APPEND, 1'b0, 0));
    send_beat(make_beat(OP_APPEND, 1'b0, 1));
    send_beat(make_beat(OP_APPEND, 1'b0, 1023));
    send_beat(make_beat(OP_APPEND, 1'b0, 1));
    send_beat(make_beat(OP_LOOKUP, 1'b0, 1));
    send_beat(make_beat(OP_LOOKUP, 1'b0, 2));
    send_beat(make_beat(OP_LOOKUP, 1'b0, 255));
    send_beat(make_beat(OP_SEARCH, 1'b0, 1));
    send_beat(make_beat(OP_SEARCH, 1'b0, 0));
    send_beat(make_beat(OP_SEARCH, 1'b0, 1023));
    send_beat(make_beat(OP_APPEND, 1'b1, 1024));
    send_beat(make_beat(OP_APPEND, 1'b1, 2047));
    send_beat(make_beat(OP_SEARCH, 1'b1, 0));
    send_beat(make_beat(OP_LOOKUP, 1'b1, 0));
    send_beat(make_beat(OP_CLEAR, 1'b0, 0));
    send_beat(make_beat(OP_LOOKUP, 1'b0, 0));
    send_beat(make_beat(OP_SEARCH, 1'b0, 0));
    send_beat(make_beat(OP_APPEND, 1'b0, 2047));
    send_beat(make_beat(OP_APPEND, 1'b0, 1024));
    send_beat(make_beat(OP_CLEAR, 1'b1, 0));
    send_beat(make_beat(OP_CLEAR, 1'b1, 0));
    send_beat(make_beat(OP_APPEND, 1'b1, 1025));

    // Random: episodes that clear a channel and then grow it. Fill episodes use
    // short runs to reach the element limit; the others use long runs to
    // overflow the slot memory. Track a rough count and end slot so that
    // lookups and searches land on live entries most of the time.
    rnd_sent = 0;
    first    = 1'b1;
    while (rnd_sent < 1200) begin
      fill      = first || ($urandom_range(9, 0) < 3);
      first     = 1'b0;
      ep_ch     = 1'($urandom_range(1, 0));
      run_left  = fill ? $urandom_range(480, 400) : $urandom_range(80, 20);
      clear_pct = fill ? 0 : 2;
      app_pct   = fill ? 85 : 60;
      app_n     = 0;
      slot_end  = 0;
      send_beat(make_beat(OP_CLEAR, ep_ch, 0));
      rnd_sent++;
      while (run_left > 0 && rnd_sent < 1200) begin
        ch = ($urandom_range(99, 0) < (fill ? 95 : 85)) ? ep_ch : !ep_ch;
        r  = $urandom_range(99, 0);
        if (r < clear_pct) begin
          send_beat(make_beat(OP_CLEAR, ch, 0));
          if (ch == ep_ch) begin
            app_n    = 0;
            slot_end = 0;
          end
        end else if (r < app_pct) begin
          r = $urandom_range(99, 0);
          if (fill) begin
            if (r < 95) len = $urandom_range(3, 1);
            else if (r < 98) len = 0;
            else len = 2047;
          end else begin
            if (r < 80) len = $urandom_range(200, 1);
            else if (r < 88) len = $urandom_range(1024, 1);
            else if (r < 94) len = 0;
            else len = $urandom_range(2047, 0);
          end
          send_beat(make_beat(OP_APPEND, ch, len));
          if (ch == ep_ch && len > 0 && slot_end + len <= 1024 && app_n < 256) begin
            app_n++;
            slot_end += len;
          end
        end else if (r < app_pct + (100 - app_pct) / 2) begin
          if ($urandom_range(99, 0) < 80)
            send_beat(make_beat(OP_LOOKUP, ch, $urandom_range((app_n + 2 > 255) ? 255 : app_n + 2, 0)));
          else
            send_beat(make_beat(OP_LOOKUP, ch, $urandom_range(255, 0)));
        end else begin
          if ($urandom_range(99, 0) < 75)
            send_beat(make_beat(OP_SEARCH, ch, $urandom_range((slot_end > 1023) ? 1023 : slot_end, 0)));
          else
            send_beat(make_beat(OP_SEARCH, ch, $urandom_range(1023, 0)));
        end
        run_left--;
        rnd_sent++;
      end
    end

    // Drain: wait for every owed result, then let the bench idle before reporting.
    while (owed != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (mismatches == 0) begin
      $display("element_slice_start_table: match");
    end else begin
      $display("element_slice_start_table: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/ess_pkg.sv
rtl/core/ess_ram.sv
rtl/core/ess_ctrl.sv
rtl/core/ess_datapath.sv
rtl/core/element_slice_start_table.sv
rtl/core/ess_checker.sv
tb/start_table_checker.sv
tb/element_slice_start_table_test.sv
